// ===== design/char_class_tokenizer_macros.svh =====
// Assertion macros shared by the tokenizer checker.
`ifndef CHAR_CLASS_TOKENIZER_MACROS_SVH
`define CHAR_CLASS_TOKENIZER_MACROS_SVH

// Concurrent assertion clocked on clk that is switched off while rst is high.
`define CCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion clocked on clk that is also checked through reset.
`define CCT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cct_pkg.sv =====
// Types, constants and byte classification functions of the tokenizer.
package cct_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [2:0] CLS_WORD    = 3'd0;
  localparam logic [2:0] CLS_NUMBER  = 3'd1;
  localparam logic [2:0] CLS_PUNCT   = 3'd2;
  localparam logic [2:0] CLS_SPACE   = 3'd3;
  localparam logic [2:0] CLS_CONTROL = 3'd4;
  localparam logic [2:0] TYPE_MIXED  = 3'd5;
  localparam logic [2:0] CLS_NONE    = 3'd7;

  localparam logic [7:0] CHAR_OPEN  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;

  typedef struct packed {
    logic       group_mode;
    logic [2:0] first_class;
    logic       class_uniform;
    logic       token_empty;
  } tok_state_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       token_end;
    logic [2:0] token_type;
    logic       text_done;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic nonempty;
    logic no_room;
  } fifo_status_t;

  localparam tok_state_t TOK_CLEAR = '{group_mode: 1'b0, first_class: CLS_WORD,
                                       class_uniform: 1'b1, token_empty: 1'b1};

  function automatic logic [2:0] byte_class(input logic [7:0] c);
    logic [2:0] cls;
    if ((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a)) begin
      cls = CLS_WORD;
    end else if ((c >= 8'h30 && c <= 8'h39) || c == 8'h2d || c == 8'h2e) begin
      cls = CLS_NUMBER;
    end else if (c[7]) begin
      cls = CLS_NONE;
    end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) begin
      cls = CLS_SPACE;
    end else if (c < 8'h20 || c == 8'h7f) begin
      cls = CLS_CONTROL;
    end else begin
      cls = CLS_PUNCT;
    end
    return cls;
  endfunction

  // Stop characters: < > + ' * / @ ; | : ~ # &
  function automatic logic is_stop(input logic [7:0] c);
    logic s;
    case (c)
      8'h3c, 8'h3e, 8'h2b, 8'h27, 8'h2a, 8'h2f, 8'h40,
      8'h3b, 8'h7c, 8'h3a, 8'h7e, 8'h23, 8'h26: s = 1'b1;
      default: s = 1'b0;
    endcase
    return s;
  endfunction

endpackage

// ===== design/cct_step.sv =====
// Handles one byte: decides the token boundary and updates the token state.
module cct_step (
  input  logic [7:0]          c,
  input  logic                last,
  input  logic [7:0]          nxt,
  input  cct_pkg::tok_state_t st_in,
  output cct_pkg::result_t    res,
  output cct_pkg::tok_state_t st_out
);
  import cct_pkg::*;

  logic       paren;
  logic       ends;
  logic [2:0] cls;
  tok_state_t st_mid;

  assign cls   = byte_class(c);
  assign paren = (c == CHAR_OPEN) || (c == CHAR_CLOSE);

  always_comb begin
    st_mid = st_in;
    res    = '0;
    res.text_done = last;
    if (paren) begin
      st_mid.group_mode = ~st_in.group_mode;
      ends = (c == CHAR_CLOSE) || last;
    end else begin
      res.has_byte = 1'b1;
      res.out_byte = c;
      if (st_in.token_empty) begin
        st_mid.first_class   = cls;
        st_mid.class_uniform = 1'b1;
        st_mid.token_empty   = 1'b0;
      end else if (cls != st_in.first_class) begin
        st_mid.class_uniform = 1'b0;
      end
      if (last) begin
        ends = 1'b1;
      end else if (st_in.group_mode) begin
        ends = 1'b0;
      end else if (is_stop(c)) begin
        ends = 1'b1;
      end else begin
        ends = (byte_class(nxt) != cls);
      end
    end

    st_out = st_mid;
    if (ends) begin
      res.token_end = 1'b1;
      if (st_mid.token_empty) begin
        res.token_type = CLS_WORD;
      end else if (st_mid.class_uniform && st_mid.first_class < TYPE_MIXED) begin
        res.token_type = st_mid.first_class;
      end else begin
        res.token_type = TYPE_MIXED;
      end
      st_out = TOK_CLEAR;
    end
  end

endmodule

// ===== design/cct_fifo.sv =====
// Result queue that takes up to two results a cycle and gives one.
module cct_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             push_cnt,
  input  cct_pkg::result_t       push_a,
  input  cct_pkg::result_t       push_b,
  input  logic                   pop,
  output cct_pkg::result_t       head,
  output cct_pkg::fifo_status_t  status
);
  import cct_pkg::*;

  result_t          mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign count_next = count + CNT_W'(push_cnt) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_cnt);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push_a;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push_b;
    end
  end

  assign head           = mem[rd_ptr];
  assign status.nonempty = (count != '0);
  // An input transfer may bring two results, so two free slots are kept.
  assign status.no_room  = (count > CNT_W'(FIFO_DEPTH - 2));

endmodule

// ===== design/char_class_tokenizer.sv =====
// Top level of the byte stream tokenizer.
// The tokenizer takes one text byte per transfer and holds it back as lookahead until
// the next byte arrives; each input transfer then yields the result for the held byte,
// plus one for the incoming byte when stream_end is set, so zero, one or two results.
// Results pass through a four-entry queue that emits one per cycle while out_stall is
// low: an input is taken in every cycle while the queue has two free slots, so a stream
// of ordinary bytes runs at one byte per cycle, and the closing byte of a text adds one
// more result. Input is stalled whenever the queue holds more than two results. Results
// reach the outputs only through the queue registers. An accepted stream_end returns the
// lookahead and token state to their reset values.
module char_class_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       stream_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       has_byte,
  output logic [7:0] out_byte,
  output logic       token_end,
  output logic [2:0] token_type,
  output logic       text_done,
  output logic       run_last
);
  import cct_pkg::*;

  logic         [7:0] held_byte;
  logic               held_valid;
  tok_state_t         tok;
  tok_state_t         tok_next;
  tok_state_t         st_held;
  tok_state_t         st_mid;
  tok_state_t         st_last;
  result_t            res_held;
  result_t            res_last;
  result_t            push_a;
  result_t            push_b;
  result_t            head;
  fifo_status_t       fstat;
  logic         [1:0] push_cnt;
  logic               accept;
  logic               pop;

  assign in_stall = fstat.no_room;
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  cct_step u_step_held (
    .c      (held_byte),
    .last   (1'b0),
    .nxt    (in_byte),
    .st_in  (tok),
    .res    (res_held),
    .st_out (st_held)
  );

  assign st_mid = held_valid ? st_held : tok;

  cct_step u_step_last (
    .c      (in_byte),
    .last   (1'b1),
    .nxt    (8'h00),
    .st_in  (st_mid),
    .res    (res_last),
    .st_out (st_last)
  );

  always_comb begin
    push_cnt = '0;
    push_a   = res_held;
    push_b   = res_last;
    push_b.run_last = 1'b1;
    tok_next = tok;
    if (accept) begin
      push_cnt = {1'b0, held_valid} + {1'b0, stream_end};
      if (held_valid) begin
        push_a.run_last = !stream_end;
      end else begin
        push_a = res_last;
        push_a.run_last = 1'b1;
      end
      // The last byte of a text always ends its token, which clears the state.
      tok_next = stream_end ? st_last : st_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_byte  <= '0;
      tok        <= TOK_CLEAR;
    end else if (accept) begin
      held_valid <= !stream_end;
      held_byte  <= stream_end ? 8'h00 : in_byte;
      tok        <= tok_next;
    end
  end

  cct_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (push_cnt),
    .push_a   (push_a),
    .push_b   (push_b),
    .pop      (pop),
    .head     (head),
    .status   (fstat)
  );

  assign out_valid  = fstat.nonempty;
  assign has_byte   = head.has_byte;
  assign out_byte   = head.out_byte;
  assign token_end  = head.token_end;
  assign token_type = head.token_type;
  assign text_done  = head.text_done;
  assign run_last   = head.run_last;

endmodule

// ===== design/cct_checker.sv =====
// Port-level checks of the tokenizer and the bind that attaches them.
`include "char_class_tokenizer_macros.svh"

module cct_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       has_byte,
  input logic [7:0] out_byte,
  input logic       token_end,
  input logic [2:0] token_type,
  input logic       text_done,
  input logic       run_last
);

  `CCT_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "results shown right after reset")
  `CCT_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(token_end) && $stable(run_last), "stalled result changed")
  `CCT_ASSERT(a_type_idle, out_valid && !token_end |-> token_type == 3'd0, "token type without token end")
  `CCT_ASSERT(a_drop_zero, out_valid && !has_byte |-> out_byte == 8'h00, "dropped byte not zero")
  `CCT_ASSERT(a_done_ends, out_valid && text_done |-> token_end && run_last, "text end does not close the token")

endmodule

bind char_class_tokenizer cct_checker u_cct_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .has_byte   (has_byte),
  .out_byte   (out_byte),
  .token_end  (token_end),
  .token_type (token_type),
  .text_done  (text_done),
  .run_last   (run_last)
);
